[rtl/swte_pkg.sv]
// Shared types and codes of the sliding window transport engine.
package swte_pkg;

    // Operation codes carried on the input channel.
    localparam logic [1:0] OP_HEADER = 2'd0;
    localparam logic [1:0] OP_SEND   = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Result kinds.
    localparam logic [2:0] KIND_DELIVER_IN   = 3'd0;
    localparam logic [2:0] KIND_DELIVER_SLOT = 3'd1;
    localparam logic [2:0] KIND_STORE_SLOT   = 3'd2;
    localparam logic [2:0] KIND_ACK          = 3'd3;
    localparam logic [2:0] KIND_SEND         = 3'd4;
    localparam logic [2:0] KIND_RESEND       = 3'd5;
    localparam logic [2:0] KIND_REFUSED      = 3'd6;
    localparam logic [2:0] KIND_DROPPED      = 3'd7;

    // Configuration register indexes.
    localparam logic [2:0] CFG_RTO_TICKS      = 3'd0;
    localparam logic [2:0] CFG_DUP_THRESHOLD  = 3'd1;
    localparam logic [2:0] CFG_INIT_SEND_SEQ  = 3'd2;
    localparam logic [2:0] CFG_INIT_EXP_SEQ   = 3'd3;
    localparam logic [2:0] CFG_INIT_PEER_WIN  = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] seq;
        logic [15:0] ack;
        logic [15:0] win;
        logic [3:0]  slot;
    } res_t;

    typedef struct packed {
        logic can_emit;
        logic out_free;
        logic pend_vld;
    } buf_status_t;

endpackage

[rtl/swte_result_buf.sv]
// Result holding stage: keeps the newest result back until it is known to be last.
module swte_result_buf (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      emit_en,
    input  swte_pkg::res_t            emit_res,
    input  logic                      finish_en,
    output swte_pkg::buf_status_t     status,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [55:0]               m_tdata,   // seq_out, ack_out, window_out, slot, zero fill
    output logic [2:0]                m_tuser,   // kind
    output logic                      m_tlast
);
    import swte_pkg::*;

    res_t pend_reg;
    logic pend_vld_reg;
    res_t out_reg;
    logic out_last_reg;
    logic m_tvalid_reg;
    logic out_free;
    logic push;

    assign out_free = !m_tvalid_reg || m_tready;
    assign push = (emit_en && pend_vld_reg) || finish_en;

    assign status.can_emit = !pend_vld_reg || out_free;
    assign status.out_free = out_free;
    assign status.pend_vld = pend_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (push) begin
                out_reg      <= pend_reg;
                out_last_reg <= finish_en;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (emit_en) begin
                pend_reg     <= emit_res;
                pend_vld_reg <= 1'b1;
            end else if (finish_en) begin
                pend_vld_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, out_reg.slot, out_reg.win, out_reg.ack, out_reg.seq};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;

endmodule

[rtl/sliding_window_transport_engine.sv]
// Top level of the sliding window transport engine.
// One event enters on the s_ channel per transfer: a received header, a send
// request or a timer tick (operation in s_tuser). The results it causes leave
// on the m_ channel in order; m_tlast marks the final result of an event, and
// an event that causes nothing produces no transfer.
// Events are taken one at a time: s_tready is high only while the engine is
// idle. The tags of unacked and reordered segments live in two memories with
// registered reads; a search walks one entry per cycle, and a drain pauses on
// a found slot while its result waits to go out. A header with ACK first scans
// the unacked tags; an in-order delivery then drains the reorder table and an
// out-of-order segment searches it for a slot. A send request scans the unacked
// tags, as does a tick when the timer expires.
// Results go through a holding stage and an output register, so the engine keeps
// working while one result waits; if m_tready stays low it stalls at its next
// result. Reset empties both tables, reloads the registers with their defaults
// and drops any result in flight. Configuration writes on cfg_wr_en load the
// register and the state it seeds; they belong in idle periods.
module sliding_window_transport_engine #(
    parameter int SEND_DEPTH        = 16,
    parameter int REORDER_DEPTH     = 16,
    parameter int MAX_PAYLOAD_BYTES = 1012
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // seq_in, ack_in, length_in, window_in, zero fill
    input  logic [3:0]  s_tuser,   // operation, parity_ok, ack_flag
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // seq_out, ack_out, window_out, slot, zero fill
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data
);
    import swte_pkg::*;

    localparam int SIW  = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
    localparam int RIW  = (REORDER_DEPTH > 1) ? $clog2(REORDER_DEPTH) : 1;
    localparam int MAXD = (SEND_DEPTH > REORDER_DEPTH) ? SEND_DEPTH : REORDER_DEPTH;
    localparam int SCW  = $clog2(MAXD + 1);
    localparam int CNTW = $clog2(SEND_DEPTH + 1);
    localparam int MPW  = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int PRW  = CNTW + 1 + MPW;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_ACKSCAN, S_DATA, S_DRAIN, S_DACK, S_RSCAN, S_RSTORE,
        S_SSCAN, S_SSTORE, S_TSCAN, S_TOUT, S_FAST, S_FINISH
    } state_t;

    state_t state_reg;

    // Configuration and protocol state.
    logic [15:0] rto_reg;
    logic [3:0]  thr_reg;
    logic [15:0] nss_reg, exp_reg, hack_reg, dup_seq_reg, pwin_reg, timer_reg;
    logic [3:0]  dup_cnt_reg;
    logic [CNTW-1:0] un_count_reg;
    logic [SEND_DEPTH-1:0]    un_valid_reg;
    logic [REORDER_DEPTH-1:0] ro_valid_reg;

    // Latched event.
    logic [1:0]  op_reg;
    logic        par_reg, ackf_reg;
    logic [15:0] seq_reg, ack_reg, win_reg;
    logic [9:0]  len_reg;

    // Scan machinery.
    logic [SCW-1:0] scan_reg, chk_idx_reg;
    logic           chk_vld_reg;
    logic           match_vld_reg, free_vld_reg;
    logic [SCW-1:0] match_reg, free_reg;
    logic [15:0]    min_tag_reg;

    // Tag memories.
    logic [15:0] un_mem [SEND_DEPTH];
    logic [15:0] ro_mem [REORDER_DEPTH];
    logic [15:0] un_rdata, ro_rdata;
    logic        un_re, ro_re, un_we, ro_we;
    logic [SIW-1:0] un_waddr;
    logic [RIW-1:0] ro_waddr;

    logic          emit_want, emit_en, hold, finish_en;
    res_t          emit_res;
    buf_status_t   bstat;
    logic          drain_hit, admit, scan_done_un, scan_done_ro;
    logic [3:0]    thr_eff;
    logic [15:0]   tick_next;
    logic [PRW-1:0] need_bytes;
    logic [SCW-1:0] pick;
    logic          pick_vld;

    assign s_tready = (state_reg == S_IDLE);

    assign thr_eff   = (thr_reg == 4'd0) ? 4'd1 : thr_reg;
    assign tick_next = (timer_reg == 16'hFFFF) ? timer_reg : timer_reg + 16'd1;
    assign need_bytes = PRW'({1'b0, un_count_reg} + 1'b1) * PRW'(MAX_PAYLOAD_BYTES);
    assign admit = need_bytes <= PRW'(pwin_reg);

    assign scan_done_un = (scan_reg == SCW'(SEND_DEPTH)) && !chk_vld_reg;
    assign scan_done_ro = (scan_reg == SCW'(REORDER_DEPTH)) && !chk_vld_reg;
    assign drain_hit = (state_reg == S_DRAIN) && chk_vld_reg
                       && ro_valid_reg[chk_idx_reg[RIW-1:0]] && (ro_rdata == exp_reg);

    assign pick_vld = match_vld_reg || free_vld_reg;
    assign pick     = match_vld_reg ? match_reg : free_reg;

    // What result, if any, the current state wants to hand out.
    always_comb begin
        emit_want = 1'b0;
        emit_res  = '0;
        unique case (state_reg)
            S_DECIDE: begin
                if (op_reg == OP_HEADER && !par_reg) begin
                    emit_want     = 1'b1;
                    emit_res.kind = KIND_DROPPED;
                    emit_res.seq  = seq_reg;
                end else if (op_reg == OP_SEND && len_reg != 10'd0 && !admit) begin
                    emit_want     = 1'b1;
                    emit_res.kind = KIND_REFUSED;
                    emit_res.seq  = nss_reg;
                    emit_res.ack  = exp_reg;
                    emit_res.win  = pwin_reg;
                end
            end
            S_DATA: begin
                if (len_reg != 10'd0 && seq_reg == exp_reg) begin
                    emit_want     = 1'b1;
                    emit_res.kind = KIND_DELIVER_IN;
                    emit_res.seq  = seq_reg;
                end
            end
            S_DRAIN: begin
                if (drain_hit) begin
                    emit_want     = 1'b1;
                    emit_res.kind = KIND_DELIVER_SLOT;
                    emit_res.seq  = exp_reg;
                    emit_res.slot = 4'(chk_idx_reg);
                end
            end
            S_DACK: begin
                emit_want     = 1'b1;
                emit_res.kind = KIND_ACK;
                emit_res.ack  = exp_reg;
                emit_res.win  = pwin_reg;
            end
            S_RSTORE: begin
                emit_want    = 1'b1;
                emit_res.seq = seq_reg;
                if (pick_vld) begin
                    emit_res.kind = KIND_STORE_SLOT;
                    emit_res.slot = 4'(pick);
                end else begin
                    emit_res.kind = KIND_DROPPED;
                end
            end
            S_SSTORE: begin
                emit_want    = 1'b1;
                emit_res.seq = nss_reg;
                emit_res.ack = exp_reg;
                emit_res.win = pwin_reg;
                if (pick_vld) begin
                    emit_res.kind = KIND_SEND;
                    emit_res.slot = 4'(pick);
                end else begin
                    emit_res.kind = KIND_REFUSED;
                end
            end
            S_TOUT: begin
                if (match_vld_reg) begin
                    emit_want     = 1'b1;
                    emit_res.kind = KIND_RESEND;
                    emit_res.seq  = min_tag_reg;
                    emit_res.slot = 4'(match_reg);
                end
            end
            S_FAST: begin
                if (dup_cnt_reg >= thr_eff) begin
                    emit_want     = 1'b1;
                    emit_res.kind = KIND_ACK;
                    emit_res.ack  = dup_seq_reg + 16'd1;
                    emit_res.win  = pwin_reg;
                end
            end
            default: ;
        endcase
    end

    assign emit_en   = emit_want && bstat.can_emit;
    assign hold      = emit_want && !bstat.can_emit;
    assign finish_en = (state_reg == S_FINISH) && bstat.pend_vld && bstat.out_free;

    assign un_re = (state_reg == S_ACKSCAN || state_reg == S_SSCAN || state_reg == S_TSCAN)
                   && (scan_reg < SCW'(SEND_DEPTH));
    assign ro_re = ((state_reg == S_DRAIN && !hold) || state_reg == S_RSCAN)
                   && (scan_reg < SCW'(REORDER_DEPTH));
    assign un_we = (state_reg == S_SSTORE) && emit_en && pick_vld;
    assign ro_we = (state_reg == S_RSTORE) && emit_en && pick_vld;
    assign un_waddr = pick[SIW-1:0];
    assign ro_waddr = pick[RIW-1:0];

    // Tags are written once per event, after every scan of that event, so a read
    // never meets a write to the same entry in flight.
    always_ff @(posedge aclk) begin
        if (un_we) begin
            un_mem[un_waddr] <= nss_reg;
        end
        if (un_re) begin
            un_rdata <= un_mem[scan_reg[SIW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (ro_we) begin
            ro_mem[ro_waddr] <= seq_reg;
        end
        if (ro_re) begin
            ro_rdata <= ro_mem[scan_reg[RIW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            rto_reg       <= 16'd1000;
            thr_reg       <= 4'd3;
            nss_reg       <= 16'd0;
            exp_reg       <= 16'd0;
            hack_reg      <= 16'd0;
            dup_cnt_reg   <= 4'd0;
            dup_seq_reg   <= 16'd0;
            pwin_reg      <= 16'd1012;
            timer_reg     <= 16'd0;
            un_count_reg  <= '0;
            un_valid_reg  <= '0;
            ro_valid_reg  <= '0;
            chk_vld_reg   <= 1'b0;
            scan_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_RTO_TICKS:     rto_reg <= cfg_wr_data;
                    CFG_DUP_THRESHOLD: thr_reg <= cfg_wr_data[3:0];
                    CFG_INIT_SEND_SEQ: begin
                        nss_reg <= cfg_wr_data;
                    end
                    CFG_INIT_EXP_SEQ: begin
                        exp_reg  <= cfg_wr_data;
                        hack_reg <= cfg_wr_data;
                    end
                    CFG_INIT_PEER_WIN: begin
                        pwin_reg <= cfg_wr_data;
                    end
                    default: ;
                endcase
            end

            // Common scan stepping; the drain state manages its own pipeline.
            if (state_reg != S_DRAIN) begin
                if (un_re || ro_re) begin
                    scan_reg    <= scan_reg + 1'b1;
                    chk_idx_reg <= scan_reg;
                    chk_vld_reg <= 1'b1;
                end else begin
                    chk_vld_reg <= 1'b0;
                end
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= s_tuser[1:0];
                        par_reg   <= s_tuser[2];
                        ackf_reg  <= s_tuser[3];
                        seq_reg   <= s_tdata[15:0];
                        ack_reg   <= s_tdata[31:16];
                        len_reg   <= s_tdata[41:32];
                        win_reg   <= s_tdata[57:42];
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    scan_reg      <= '0;
                    match_vld_reg <= 1'b0;
                    free_vld_reg  <= 1'b0;
                    unique case (op_reg)
                        OP_HEADER: begin
                            if (!par_reg) begin
                                if (!hold) state_reg <= S_FAST;
                            end else begin
                                pwin_reg <= win_reg;
                                if (ackf_reg) begin
                                    timer_reg <= 16'd0;
                                    if (ack_reg > hack_reg) begin
                                        hack_reg    <= ack_reg;
                                        dup_cnt_reg <= 4'd0;
                                    end else if (ack_reg == hack_reg) begin
                                        if (dup_cnt_reg != 4'd15)
                                            dup_cnt_reg <= dup_cnt_reg + 4'd1;
                                        dup_seq_reg <= seq_reg;
                                    end
                                    state_reg <= S_ACKSCAN;
                                end else begin
                                    state_reg <= S_DATA;
                                end
                            end
                        end
                        OP_SEND: begin
                            if (len_reg == 10'd0) begin
                                state_reg <= S_FAST;
                            end else if (admit) begin
                                state_reg <= S_SSCAN;
                            end else if (!hold) begin
                                state_reg <= S_FAST;
                            end
                        end
                        OP_TICK: begin
                            if (tick_next < rto_reg) begin
                                timer_reg <= tick_next;
                                state_reg <= S_FAST;
                            end else begin
                                timer_reg <= 16'd0;
                                state_reg <= S_TSCAN;
                            end
                        end
                        default: state_reg <= S_FAST;
                    endcase
                end
                S_ACKSCAN: begin
                    if (chk_vld_reg && un_valid_reg[chk_idx_reg[SIW-1:0]]
                        && un_rdata < ack_reg) begin
                        un_valid_reg[chk_idx_reg[SIW-1:0]] <= 1'b0;
                        un_count_reg <= un_count_reg - 1'b1;
                    end
                    if (scan_done_un) state_reg <= S_DATA;
                end
                S_DATA: begin
                    scan_reg <= '0;
                    if (len_reg == 10'd0 || seq_reg < exp_reg) begin
                        state_reg <= S_FAST;
                    end else if (seq_reg == exp_reg) begin
                        if (!hold) begin
                            exp_reg   <= exp_reg + 16'd1;
                            state_reg <= S_DRAIN;
                        end
                    end else begin
                        state_reg <= S_RSCAN;
                    end
                end
                S_DRAIN: begin
                    if (drain_hit) begin
                        // A hit restarts the walk from entry zero for the next sequence.
                        if (!hold) begin
                            ro_valid_reg[chk_idx_reg[RIW-1:0]] <= 1'b0;
                            exp_reg     <= exp_reg + 16'd1;
                            scan_reg    <= '0;
                            chk_vld_reg <= 1'b0;
                        end
                    end else if (scan_done_ro) begin
                        state_reg <= S_DACK;
                    end else if (ro_re) begin
                        scan_reg    <= scan_reg + 1'b1;
                        chk_idx_reg <= scan_reg;
                        chk_vld_reg <= 1'b1;
                    end else begin
                        chk_vld_reg <= 1'b0;
                    end
                end
                S_DACK: begin
                    if (!hold) state_reg <= S_FAST;
                end
                S_RSCAN: begin
                    if (chk_vld_reg) begin
                        if (ro_valid_reg[chk_idx_reg[RIW-1:0]]) begin
                            if (ro_rdata == seq_reg && !match_vld_reg) begin
                                match_vld_reg <= 1'b1;
                                match_reg     <= chk_idx_reg;
                            end
                        end else if (!free_vld_reg) begin
                            free_vld_reg <= 1'b1;
                            free_reg     <= chk_idx_reg;
                        end
                    end
                    if (scan_done_ro) state_reg <= S_RSTORE;
                end
                S_RSTORE: begin
                    if (!hold) begin
                        if (pick_vld) ro_valid_reg[pick[RIW-1:0]] <= 1'b1;
                        state_reg <= S_FAST;
                    end
                end
                S_SSCAN: begin
                    if (chk_vld_reg) begin
                        if (un_valid_reg[chk_idx_reg[SIW-1:0]]) begin
                            if (un_rdata == nss_reg && !match_vld_reg) begin
                                match_vld_reg <= 1'b1;
                                match_reg     <= chk_idx_reg;
                            end
                        end else if (!free_vld_reg) begin
                            free_vld_reg <= 1'b1;
                            free_reg     <= chk_idx_reg;
                        end
                    end
                    if (scan_done_un) state_reg <= S_SSTORE;
                end
                S_SSTORE: begin
                    if (!hold) begin
                        if (pick_vld) begin
                            un_valid_reg[pick[SIW-1:0]] <= 1'b1;
                            if (!match_vld_reg) un_count_reg <= un_count_reg + 1'b1;
                            nss_reg <= nss_reg + 16'd1;
                        end
                        state_reg <= S_FAST;
                    end
                end
                S_TSCAN: begin
                    // Strict compare keeps the lowest-numbered entry among equal tags.
                    if (chk_vld_reg && un_valid_reg[chk_idx_reg[SIW-1:0]]
                        && (!match_vld_reg || un_rdata < min_tag_reg)) begin
                        match_vld_reg <= 1'b1;
                        match_reg     <= chk_idx_reg;
                        min_tag_reg   <= un_rdata;
                    end
                    if (scan_done_un) state_reg <= S_TOUT;
                end
                S_TOUT: begin
                    if (!hold) state_reg <= S_FAST;
                end
                S_FAST: begin
                    if (!hold) begin
                        if (emit_want) dup_cnt_reg <= 4'd0;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!bstat.pend_vld || bstat.out_free) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    swte_result_buf u_rbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .emit_en   (emit_en),
        .emit_res  (emit_res),
        .finish_en (finish_en),
        .status    (bstat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // The occupancy counter must track the unacked valid bits exactly.
    a_un_count: assert property (@(posedge aclk) disable iff (!aresetn)
        un_count_reg == CNTW'($countones(un_valid_reg)))
        else $error("unacked count out of step with valid bits");

    // Only one event is ever in progress.
    a_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second event accepted while busy");

    // Every result of an event is released before the next event is taken.
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !bstat.pend_vld)
        else $error("held result left over at idle");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the sliding window transport engine.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swte_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES   = 800;
    localparam int MAX_BYTES     = 1012;

    typedef struct {
        logic [2:0]  kind;
        logic [15:0] seq;
        logic [15:0] ack;
        logic [15:0] win;
        logic [3:0]  slot;
        logic        last;
    } seg_result_t;

    // Tracks the engine's state and the results it still owes.
    class swte_scoreboard;
        logic [15:0] rto_ticks;
        logic [3:0]  dup_threshold;
        logic [15:0] init_send_seq;
        logic [15:0] init_exp_seq;
        logic [15:0] init_peer_win;
        logic [15:0] next_send_seq;
        logic [15:0] expected_seq;
        logic [15:0] highest_ack;
        logic [3:0]  dup_count;
        logic [15:0] dup_seq;
        logic [15:0] peer_window;
        logic [15:0] timer_count;
        bit          unacked_vld [16];
        logic [15:0] unacked_tag [16];
        bit          reorder_vld [16];
        logic [15:0] reorder_tag [16];
        seg_result_t owed_results[$];
        int          errors;
        int          events_seen;
        int          results_seen;
        int          kind_hits [8];

        function new();
            rto_ticks     = 16'd1000;
            dup_threshold = 4'd3;
            init_send_seq = '0;
            init_exp_seq  = '0;
            init_peer_win = 16'd1012;
            next_send_seq = '0;
            expected_seq  = '0;
            highest_ack   = '0;
            dup_count     = '0;
            dup_seq       = '0;
            peer_window   = 16'd1012;
            timer_count   = '0;
            for (int i = 0; i < 16; i++) begin
                unacked_vld[i] = 0;
                unacked_tag[i] = '0;
                reorder_vld[i] = 0;
                reorder_tag[i] = '0;
            end
            errors = 0;
            events_seen = 0;
            results_seen = 0;
            foreach (kind_hits[k]) kind_hits[k] = 0;
        endfunction

        function void write_reg(logic [2:0] addr, logic [15:0] data);
            case (addr)
                CFG_RTO_TICKS: rto_ticks = data;
                CFG_DUP_THRESHOLD: dup_threshold = data[3:0];
                CFG_INIT_SEND_SEQ: begin
                    init_send_seq = data;
                    next_send_seq = data;
                end
                CFG_INIT_EXP_SEQ: begin
                    init_exp_seq = data;
                    expected_seq = data;
                    highest_ack  = data;
                end
                CFG_INIT_PEER_WIN: begin
                    init_peer_win = data;
                    peer_window   = data;
                end
                default: ;
            endcase
        endfunction

        function void owe(logic [2:0] kind, logic [15:0] seq, logic [15:0] ack,
                          logic [15:0] win, logic [3:0] slot);
            seg_result_t r;
            r.kind = kind;
            r.seq  = seq;
            r.ack  = ack;
            r.win  = win;
            r.slot = slot;
            r.last = 1'b0;
            owed_results.push_back(r);
        endfunction

        function void take_header(logic parity, logic ackf, logic [15:0] seq,
                                  logic [15:0] ack, logic [9:0] len, logic [15:0] win);
            int  pick;
            bit  found;
            if (!parity) begin
                owe(KIND_DROPPED, seq, '0, '0, '0);
                return;
            end
            if (ackf) begin
                timer_count = '0;
                if (ack > highest_ack) begin
                    highest_ack = ack;
                    dup_count   = '0;
                end else if (ack == highest_ack) begin
                    if (dup_count != 4'd15) dup_count++;
                    dup_seq = seq;
                end
                for (int i = 0; i < 16; i++)
                    if (unacked_vld[i] && unacked_tag[i] < ack) unacked_vld[i] = 0;
            end
            peer_window = win;
            if (len == 0) return;
            if (seq == expected_seq) begin
                owe(KIND_DELIVER_IN, seq, '0, '0, '0);
                expected_seq++;
                found = 1;
                while (found) begin
                    found = 0;
                    for (int i = 0; i < 16 && !found; i++) begin
                        if (reorder_vld[i] && reorder_tag[i] == expected_seq) begin
                            owe(KIND_DELIVER_SLOT, expected_seq, '0, '0, i[3:0]);
                            reorder_vld[i] = 0;
                            expected_seq++;
                            found = 1;
                        end
                    end
                end
                owe(KIND_ACK, '0, expected_seq, peer_window, '0);
            end else if (seq > expected_seq) begin
                pick = -1;
                for (int i = 0; i < 16 && pick < 0; i++)
                    if (reorder_vld[i] && reorder_tag[i] == seq) pick = i;
                for (int i = 0; i < 16 && pick < 0; i++)
                    if (!reorder_vld[i]) pick = i;
                if (pick < 0) begin
                    owe(KIND_DROPPED, seq, '0, '0, '0);
                    return;
                end
                reorder_vld[pick] = 1;
                reorder_tag[pick] = seq;
                owe(KIND_STORE_SLOT, seq, '0, '0, pick[3:0]);
            end
        endfunction

        function void take_send(logic [9:0] len);
            int count;
            int pick;
            count = 0;
            pick  = -1;
            if (len == 0) return;
            for (int i = 0; i < 16; i++) if (unacked_vld[i]) count++;
            if (count < int'(peer_window) / MAX_BYTES) begin
                for (int i = 0; i < 16 && pick < 0; i++)
                    if (unacked_vld[i] && unacked_tag[i] == next_send_seq) pick = i;
                for (int i = 0; i < 16 && pick < 0; i++)
                    if (!unacked_vld[i]) pick = i;
            end
            if (pick < 0) begin
                owe(KIND_REFUSED, next_send_seq, expected_seq, peer_window, '0);
                return;
            end
            unacked_vld[pick] = 1;
            unacked_tag[pick] = next_send_seq;
            owe(KIND_SEND, next_send_seq, expected_seq, peer_window, pick[3:0]);
            next_send_seq++;
        endfunction

        function void take_tick();
            int pick;
            pick = -1;
            if (timer_count != 16'hFFFF) timer_count++;
            if (timer_count < rto_ticks) return;
            timer_count = '0;
            for (int i = 0; i < 16; i++)
                if (unacked_vld[i] && (pick < 0 || unacked_tag[i] < unacked_tag[pick]))
                    pick = i;
            if (pick >= 0) owe(KIND_RESEND, unacked_tag[pick], '0, '0, pick[3:0]);
        endfunction

        // Called once for every accepted input transfer.
        function void note_event(logic [1:0] op, logic parity, logic ackf,
                                 logic [15:0] seq, logic [15:0] ack, logic [9:0] len,
                                 logic [15:0] win);
            int before_n;
            logic [3:0] thr;
            before_n = owed_results.size();
            events_seen++;
            case (op)
                OP_HEADER: take_header(parity, ackf, seq, ack, len, win);
                OP_SEND:   take_send(len);
                OP_TICK:   take_tick();
                default: ;
            endcase
            thr = (dup_threshold == 0) ? 4'd1 : dup_threshold;
            if (dup_count >= thr) begin
                dup_count = '0;
                owe(KIND_ACK, '0, dup_seq + 16'd1, peer_window, '0);
            end
            if (owed_results.size() > before_n) owed_results[$].last = 1'b1;
        endfunction

        function void check_result(logic [2:0] kind, logic [15:0] seq, logic [15:0] ack,
                                   logic [15:0] win, logic [3:0] slot, logic last);
            seg_result_t e;
            results_seen++;
            kind_hits[kind]++;
            if (owed_results.size() == 0) begin
                $error("unexpected result transfer: kind %0d seq %0d", kind, seq);
                errors++;
                return;
            end
            e = owed_results.pop_front();
            if (kind !== e.kind) begin
                $error("kind: expected %0d, got %0d", e.kind, kind); errors++;
            end
            if (seq !== e.seq) begin
                $error("seq_out: expected %0d, got %0d", e.seq, seq); errors++;
            end
            if (ack !== e.ack) begin
                $error("ack_out: expected %0d, got %0d", e.ack, ack); errors++;
            end
            if (win !== e.win) begin
                $error("window_out: expected %0d, got %0d", e.win, win); errors++;
            end
            if (slot !== e.slot) begin
                $error("slot: expected %0d, got %0d", e.slot, slot); errors++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, last); errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // seq_in, ack_in, length_in, window_in, zero fill
    logic [3:0]  s_tuser;   // operation, parity_ok, ack_flag
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // seq_out, ack_out, window_out, slot, zero fill
    logic [2:0]  m_tuser;   // kind
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_wr_data;

    swte_scoreboard sb;
    bit quiet;
    int hold_requests;
    int cycle_count = 0;

    sliding_window_transport_engine dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random back-pressure plus one long hold-off on request.
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                                m_tdata[51:48], m_tlast);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 38);
            end
        end
    end

    task automatic write_cfg(logic [2:0] addr, logic [15:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        @(posedge aclk);
        sb.write_reg(addr, data);
    endtask

    task automatic load_settings(logic [15:0] rto, logic [15:0] thr, logic [15:0] iss,
                                 logic [15:0] ies, logic [15:0] ipw);
        write_cfg(CFG_RTO_TICKS, rto);
        write_cfg(CFG_DUP_THRESHOLD, thr);
        write_cfg(CFG_INIT_SEND_SEQ, iss);
        write_cfg(CFG_INIT_EXP_SEQ, ies);
        write_cfg(CFG_INIT_PEER_WIN, ipw);
        cfg_wr_en <= 1'b0;
    endtask

    // Waits out every owed result, then gives an event that causes nothing time to end.
    task automatic drain();
        while (sb.owed_results.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Offers one event and returns at the edge where it is accepted.
    task automatic send_event(logic [1:0] op, logic parity, logic ackf, logic [15:0] seq,
                              logic [15:0] ack, logic [9:0] len, logic [15:0] win);
        if (!quiet && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {ackf, parity, op};
        s_tdata  <= {6'd0, win, len, ack, seq};
        do @(posedge aclk); while (!s_tready);
        sb.note_event(op, parity, ackf, seq, ack, len, win);
    endtask

    task automatic idle_input();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // One random event, mostly shaped around the tracked connection state.
    task automatic random_event();
        int          r;
        logic [15:0] seq;
        logic [15:0] ack;
        logic [9:0]  len;
        logic [15:0] win;
        r   = $urandom_range(99);
        len = ($urandom_range(9) == 0) ? 10'd1012 : 10'($urandom_range(1, MAX_BYTES));
        win = 16'($urandom_range(0, 18) * MAX_BYTES + $urandom_range(0, 40));
        if (r < 45) begin
            seq = sb.expected_seq + 16'($urandom_range(0, 6)) - 16'd1;
            case ($urandom_range(2))
                0: ack = sb.highest_ack;
                1: ack = sb.next_send_seq - 16'($urandom_range(0, 3));
                default: ack = 16'($urandom);
            endcase
            if ($urandom_range(19) == 0) len = '0;
            send_event(OP_HEADER, $urandom_range(19) != 0, $urandom_range(4) != 0,
                       seq, ack, len, win);
        end else if (r < 70) begin
            send_event(OP_SEND, 1'b1, 1'b0, 16'($urandom), 16'($urandom),
                       ($urandom_range(15) == 0) ? 10'd0 : len, 16'($urandom));
        end else if (r < 90) begin
            send_event(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                       16'($urandom), 16'($urandom), 10'($urandom), 16'($urandom));
        end else begin
            send_event(2'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                       16'($urandom), 16'($urandom), 10'($urandom_range(0, 1023)),
                       16'($urandom));
        end
    endtask

    initial begin
        sb = new();
        quiet = 0;
        hold_requests = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wr_data = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: fast timeout and threshold of one.
        load_settings(16'd1, 16'd1, 16'd0, 16'd0, 16'd0);
        send_event(OP_HEADER, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 10'd1012, 16'hFFFF);
        send_event(OP_HEADER, 1'b1, 1'b0, 16'd0, 16'd0, 10'd1012, 16'hFFFF);
        send_event(OP_HEADER, 1'b1, 1'b0, 16'd2, 16'd0, 10'd1, 16'd3036);
        send_event(OP_HEADER, 1'b1, 1'b0, 16'd2, 16'd0, 10'd5, 16'd3036);
        send_event(OP_HEADER, 1'b1, 1'b0, 16'd3, 16'd0, 10'd5, 16'd3036);
        send_event(OP_HEADER, 1'b1, 1'b0, 16'd1, 16'd0, 10'd5, 16'd3036);
        send_event(OP_HEADER, 1'b1, 1'b0, 16'd0, 16'd0, 10'd5, 16'd3036);
        send_event(OP_HEADER, 1'b1, 1'b0, 16'd4, 16'd0, 10'd0, 16'd2024);
        send_event(OP_SEND, 1'b1, 1'b0, 16'd0, 16'd0, 10'd0, 16'd0);
        send_event(OP_SEND, 1'b1, 1'b0, 16'd0, 16'd0, 10'd1, 16'd0);
        send_event(OP_SEND, 1'b1, 1'b0, 16'd0, 16'd0, 10'd1012, 16'd0);
        send_event(OP_SEND, 1'b1, 1'b0, 16'd0, 16'd0, 10'd100, 16'd0);
        send_event(OP_TICK, 1'b0, 1'b0, 16'd0, 16'd0, 10'd0, 16'd0);
        send_event(OP_HEADER, 1'b1, 1'b1, 16'd4, 16'd0, 10'd0, 16'd2024);
        send_event(OP_HEADER, 1'b1, 1'b1, 16'd9, 16'd1, 10'd0, 16'd2024);
        send_event(OP_HEADER, 1'b1, 1'b1, 16'd7, 16'd0, 10'd0, 16'd2024);
        send_event(OP_HEADER, 1'b1, 1'b1, 16'd4, 16'd2, 10'd0, 16'd0);
        send_event(OP_TICK, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 10'h3FF, 16'hFFFF);
        send_event(2'd3, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 10'h3FF, 16'hFFFF);
        idle_input();
        drain();

        // Near the top of the sequence space, where wrap is not honored.
        load_settings(16'd5, 16'd3, 16'd65530, 16'd65533, 16'd16192);
        for (int n = 0; n < 90; n++) begin
            if (n == 40) hold_requests++;
            random_event();
        end
        idle_input();
        drain();

        load_settings(16'd65535, 16'd15, 16'd1234, 16'd40000, 16'd65535);
        quiet = 1;
        for (int n = 0; n < 70; n++) random_event();
        quiet = 0;
        for (int n = 0; n < 60; n++) random_event();
        idle_input();
        drain();

        // A zero threshold counts as one.
        load_settings(16'd3, 16'd0, 16'd100, 16'd200, 16'd5000);
        for (int n = 0; n < 130; n++) random_event();
        idle_input();
        drain();

        $display("Ran %0d events with %0d result transfers over four register settings.",
                 sb.events_seen, sb.results_seen);
        $display("Result kinds 0 to 7 seen: %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.kind_hits[0], sb.kind_hits[1], sb.kind_hits[2], sb.kind_hits[3],
                 sb.kind_hits[4], sb.kind_hits[5], sb.kind_hits[6], sb.kind_hits[7]);
        if (sb.errors == 0 && sb.owed_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (sb.owed_results.size() > 0)
                $error("%0d expected results never arrived", sb.owed_results.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/swte_pkg.sv
rtl/swte_result_buf.sv
rtl/sliding_window_transport_engine.sv
dv/tb_top.sv
